@@ rtl/core/msha_pkg.sv @@
// ----------------------------------------------------------------------------
// msha_pkg
// Types, register codes, fixed levels and reset values shared by the
// multi-sensor hysteresis alarm.
// ----------------------------------------------------------------------------
package msha_pkg;

  // Field widths
  localparam int IDX_W     = 5;
  localparam int MODEL_W   = 2;
  localparam int READING_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // Number of slots that the index field can address
  localparam int INDEX_SLOTS = 2 ** IDX_W;

  // Default slot count
  localparam int SENSOR_SLOTS_DEF = 32;

  // Sensor model codes
  localparam logic [MODEL_W-1:0] MODEL_OTHER = 2'd0;
  localparam logic [MODEL_W-1:0] MODEL_CO    = 2'd1;
  localparam logic [MODEL_W-1:0] MODEL_SEVEN = 2'd2;

  // Level register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CO_SET     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CO_CLEAR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CO2_SET    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CO2_CLEAR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TVOC_SET   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TVOC_CLEAR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PM25_SET   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PM25_CLEAR = 3'd7;

  // Level register reset values
  localparam logic [CFG_W-1:0] CO_SET_RST     = 16'd2500;
  localparam logic [CFG_W-1:0] CO_CLEAR_RST   = 16'd2000;
  localparam logic [CFG_W-1:0] CO2_SET_RST    = 16'd1000;
  localparam logic [CFG_W-1:0] CO2_CLEAR_RST  = 16'd800;
  localparam logic [CFG_W-1:0] TVOC_SET_RST   = 16'd600;
  localparam logic [CFG_W-1:0] TVOC_CLEAR_RST = 16'd500;
  localparam logic [CFG_W-1:0] PM25_SET_RST   = 16'd35;
  localparam logic [CFG_W-1:0] PM25_CLEAR_RST = 16'd25;

  // Fixed levels for CH2O and PM10
  localparam logic [READING_W-1:0] CH2O_SET_LEVEL   = 16'd80;
  localparam logic [READING_W-1:0] CH2O_CLEAR_LEVEL = 16'd70;
  localparam logic [READING_W-1:0] PM10_SET_LEVEL   = 16'd50;
  localparam logic [READING_W-1:0] PM10_CLEAR_LEVEL = 16'd40;

  // One sensor report
  typedef struct packed {
    logic                 scan_done;
    logic [IDX_W-1:0]     sensor_index;
    logic                 online;
    logic [MODEL_W-1:0]   model_code;
    logic [READING_W-1:0] co_reading;
    logic [READING_W-1:0] co2_reading;
    logic [READING_W-1:0] ch2o_reading;
    logic [READING_W-1:0] tvoc_reading;
    logic [READING_W-1:0] pm25_reading;
    logic [READING_W-1:0] pm10_reading;
  } msha_report_t;

  // One alarm result
  typedef struct packed {
    logic [IDX_W-1:0] index_out;
    logic             slot_alarm;
    logic             any_alarm;
  } msha_result_t;

  // Programmable set and clear levels
  typedef struct packed {
    logic [CFG_W-1:0] co_set_level;
    logic [CFG_W-1:0] co_clear_level;
    logic [CFG_W-1:0] co2_set_level;
    logic [CFG_W-1:0] co2_clear_level;
    logic [CFG_W-1:0] tvoc_set_level;
    logic [CFG_W-1:0] tvoc_clear_level;
    logic [CFG_W-1:0] pm25_set_level;
    logic [CFG_W-1:0] pm25_clear_level;
  } msha_levels_t;

endpackage

@@ rtl/core/msha_if.sv @@
// ----------------------------------------------------------------------------
// msha_if
// Valid/ready channels for sensor reports and alarm results.
// ----------------------------------------------------------------------------
interface msha_report_if;
  logic                   valid;
  logic                   ready;
  msha_pkg::msha_report_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface msha_result_if;
  logic                   valid;
  logic                   ready;
  msha_pkg::msha_result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/msha_cfg.sv @@
// ----------------------------------------------------------------------------
// msha_cfg
// Level registers, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module msha_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [msha_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msha_pkg::CFG_W-1:0]         cfg_data,
  output msha_pkg::msha_levels_t             levels
);

  // Load defaults on reset, otherwise update the addressed level
  always_ff @(posedge clk) begin
    if (rst) begin
      levels.co_set_level     <= msha_pkg::CO_SET_RST;
      levels.co_clear_level   <= msha_pkg::CO_CLEAR_RST;
      levels.co2_set_level    <= msha_pkg::CO2_SET_RST;
      levels.co2_clear_level  <= msha_pkg::CO2_CLEAR_RST;
      levels.tvoc_set_level   <= msha_pkg::TVOC_SET_RST;
      levels.tvoc_clear_level <= msha_pkg::TVOC_CLEAR_RST;
      levels.pm25_set_level   <= msha_pkg::PM25_SET_RST;
      levels.pm25_clear_level <= msha_pkg::PM25_CLEAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msha_pkg::REG_CO_SET:     levels.co_set_level     <= cfg_data;
        msha_pkg::REG_CO_CLEAR:   levels.co_clear_level   <= cfg_data;
        msha_pkg::REG_CO2_SET:    levels.co2_set_level    <= cfg_data;
        msha_pkg::REG_CO2_CLEAR:  levels.co2_clear_level  <= cfg_data;
        msha_pkg::REG_TVOC_SET:   levels.tvoc_set_level   <= cfg_data;
        msha_pkg::REG_TVOC_CLEAR: levels.tvoc_clear_level <= cfg_data;
        msha_pkg::REG_PM25_SET:   levels.pm25_set_level   <= cfg_data;
        msha_pkg::REG_PM25_CLEAR: levels.pm25_clear_level <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/msha_hyst.sv @@
// ----------------------------------------------------------------------------
// msha_hyst
// Hysteresis decision: next alarm bit of one sensor from its current bit,
// its model, its online flag and its readings.
// ----------------------------------------------------------------------------
module msha_hyst (
  input  logic                   cur_alarm,
  input  msha_pkg::msha_report_t report,
  input  msha_pkg::msha_levels_t levels,
  output logic                   next_alarm
);

  logic co_above;
  logic co_below;
  logic seven_above;
  logic seven_below;

  // CO sensor thresholds
  assign co_above = report.co_reading > levels.co_set_level;
  assign co_below = report.co_reading < levels.co_clear_level;

  // Seven-in-one: raise on any reading above, drop only when all are below
  assign seven_above = (report.co2_reading  > levels.co2_set_level)  ||
                       (report.ch2o_reading > msha_pkg::CH2O_SET_LEVEL) ||
                       (report.tvoc_reading > levels.tvoc_set_level) ||
                       (report.pm25_reading > levels.pm25_set_level) ||
                       (report.pm10_reading > msha_pkg::PM10_SET_LEVEL);
  assign seven_below = (report.co2_reading  < levels.co2_clear_level)  &&
                       (report.ch2o_reading < msha_pkg::CH2O_CLEAR_LEVEL) &&
                       (report.tvoc_reading < levels.tvoc_clear_level) &&
                       (report.pm25_reading < levels.pm25_clear_level) &&
                       (report.pm10_reading < msha_pkg::PM10_CLEAR_LEVEL);

  // Select by model; offline sensors and other models drop the alarm
  always_comb begin
    next_alarm = 1'b0;
    if (report.online) begin
      unique case (report.model_code)
        msha_pkg::MODEL_CO:    next_alarm = cur_alarm ? !co_below : co_above;
        msha_pkg::MODEL_SEVEN: next_alarm = cur_alarm ? !seven_below : seven_above;
        default:               next_alarm = 1'b0;
      endcase
    end
  end

endmodule

@@ rtl/core/multi_sensor_hysteresis_alarm.sv @@
// ----------------------------------------------------------------------------
// multi_sensor_hysteresis_alarm
// Per-sensor alarm bits with set/clear hysteresis, updated by sensor reports.
// ----------------------------------------------------------------------------
// Pipeline: an accepted report passes through the input register, then the
//   result register, which is written together with the alarm update.
// Throughput: one report per cycle while alarm_out is ready; the alarm-bit update is a single pass.
// Reset: alarm bits cleared, both pipeline registers empty, levels loaded
//   with their default values.
// ----------------------------------------------------------------------------
module multi_sensor_hysteresis_alarm #(
  parameter int SENSOR_SLOTS = msha_pkg::SENSOR_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [msha_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [msha_pkg::CFG_W-1:0]     cfg_data,
  msha_report_if.sink                    sensor_in,
  msha_result_if.source                  alarm_out
);

  // Only slots that the index field can reach need storage
  localparam int SLOTS_USED = (SENSOR_SLOTS < msha_pkg::INDEX_SLOTS) ?
                              SENSOR_SLOTS : msha_pkg::INDEX_SLOTS;

  msha_pkg::msha_levels_t levels;
  msha_pkg::msha_report_t in_q;
  msha_pkg::msha_result_t out_q;
  msha_pkg::msha_result_t result;
  logic                   in_vld;
  logic                   out_vld;
  logic                   advance;
  logic [SLOTS_USED-1:0]  alarm_bits;
  logic [SLOTS_USED-1:0]  alarm_bits_next;
  logic [SLOTS_USED-1:0]  hit;
  logic                   cur_alarm;
  logic                   new_alarm;

  msha_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .levels    (levels)
  );

  // Move the held request on when the result register is free or draining
  assign advance         = in_vld && (!out_vld || alarm_out.ready);
  assign sensor_in.ready = !in_vld || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (sensor_in.ready) begin
      in_vld <= sensor_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sensor_in.ready && sensor_in.valid) begin
      in_q <= sensor_in.data;
    end
  end

  // Decode the slot; indexes beyond the slot count match nothing
  always_comb begin
    for (int i = 0; i < SLOTS_USED; i++) begin
      hit[i] = (in_q.sensor_index == msha_pkg::IDX_W'(i));
    end
  end

  assign cur_alarm = |(alarm_bits & hit);

  msha_hyst u_hyst (
    .cur_alarm  (cur_alarm),
    .report     (in_q),
    .levels     (levels),
    .next_alarm (new_alarm)
  );

  // Update only the addressed slot, and only once the scan is done
  always_comb begin
    for (int i = 0; i < SLOTS_USED; i++) begin
      alarm_bits_next[i] = (hit[i] && in_q.scan_done) ? new_alarm : alarm_bits[i];
    end
  end

  // Result from the updated bits
  always_comb begin
    result.index_out  = in_q.sensor_index;
    result.slot_alarm = |(alarm_bits_next & hit);
    result.any_alarm  = |alarm_bits_next;
  end

  // Alarm store
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_bits <= '0;
    end else if (advance) begin
      alarm_bits <= alarm_bits_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (alarm_out.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign alarm_out.valid = out_vld;
  assign alarm_out.data  = out_q;

  // Bits hold while the scan is not done
  a_frozen_until_scan: assert property (@(posedge clk) disable iff (rst)
    advance && !in_q.scan_done |=> $stable(alarm_bits))
    else $error("alarm bits changed before scan done");

  // Offline sensor drops its alarm
  a_offline_clears: assert property (@(posedge clk) disable iff (rst)
    advance && in_q.scan_done && !in_q.online |=> !alarm_out.data.slot_alarm)
    else $error("offline sensor kept its alarm");

  // A sensor alarm always shows in the summary
  a_any_covers_sensor: assert property (@(posedge clk) disable iff (rst)
    alarm_out.valid && alarm_out.data.slot_alarm |-> alarm_out.data.any_alarm)
    else $error("sensor alarm without summary alarm");

  // Summary matches the store just written
  a_any_matches_store: assert property (@(posedge clk) disable iff (rst)
    advance |=> alarm_out.data.any_alarm == (|alarm_bits))
    else $error("summary alarm differs from stored bits");

endmodule
